// File: src/hwc_pkg.sv
// Shared types and constants for the hit time-window clusterer.
// Used by every module of the block; no dependencies of its own.
package hwc_pkg;

   localparam int NUM_CLASSES = 4;
   localparam int TIME_W = 32;
   localparam int ENERGY_W = 20;
   localparam int SUM_W = 32;
   localparam int TAG_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam int HIT_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 4;

   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd1000;
   localparam logic [TIME_W-1:0] CUTOFF_RESET = 32'd1000000000;

   // register index, taken from paddr bit 2
   localparam logic REG_WINDOW = 1'b0;
   localparam logic REG_CUTOFF = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]                       hit_time;
      logic [NUM_CLASSES-1:0][ENERGY_W-1:0]    energy;
      logic [TAG_W-1:0]                        tag;
      logic                                    last;
   } raw_hit_type;

   typedef struct packed {
      raw_hit_type hit;
      logic        over_cutoff;
   } hit_type;

   typedef struct packed {
      logic [TIME_W-1:0]                    cluster_start;
      logic [TIME_W-1:0]                    cluster_end;
      logic [NUM_CLASSES-1:0][SUM_W-1:0]    sums;
      logic [SUM_W-1:0]                     total;
      logic [TAG_W-1:0]                     tag;
      logic                                 event_final;
      logic                                 last_of_item;
   } rsp_type;

   // result slots the engine can write in the same cycle
   typedef struct packed {
      logic a_valid;
      logic b_valid;
   } push_type;

endpackage

// File: src/hwc_hit_queue.sv
// Front part: accepts hits, flags those past the late cutoff, and queues them.
// Depends on hwc_pkg.
module hwc_hit_queue #(
   parameter int DEPTH = hwc_pkg::HIT_QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push_valid,
   output logic                              push_ready,
   input  hwc_pkg::raw_hit_type              push_item,
   input  logic [hwc_pkg::TIME_W-1:0]        late_cutoff,
   input  logic                              pop,
   output logic                              head_valid,
   output hwc_pkg::hit_type                  head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hwc_pkg::hit_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push;
   hwc_pkg::hit_type     classified;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign push       = push_valid & push_ready;
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];

   // classify against the cutoff on the way in
   always_comb begin
      classified.hit         = push_item;
      classified.over_cutoff = (push_item.hit_time > late_cutoff);
   end

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = CNT_W'(count_ff + CNT_W'(push) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold item storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// File: src/hwc_cluster_engine.sv
// Back part: applies one queued hit per cycle while the result queue has room
// to the open cluster and writes up to two finished clusters. Depends on hwc_pkg.
module hwc_cluster_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hwc_pkg::TIME_W-1:0]    window_length,
   input  logic                          head_valid,
   input  hwc_pkg::hit_type              head_item,
   input  logic                          room,
   output logic                          pop,
   output hwc_pkg::push_type             push,
   output hwc_pkg::rsp_type              slot_a,
   output hwc_pkg::rsp_type              slot_b
);

   localparam int TOT_W = hwc_pkg::SUM_W + 3;

   logic                                                 open_ff, open_in;
   logic                                                 cut_ff, cut_in;
   logic [hwc_pkg::TIME_W-1:0]                           start_ff, start_in;
   logic [hwc_pkg::TIME_W-1:0]                           end_ff, end_in;
   logic [hwc_pkg::NUM_CLASSES-1:0][hwc_pkg::SUM_W-1:0]  sums_ff, sums_in;
   logic [hwc_pkg::SUM_W-1:0]                            total_ff, total_in;
   logic [hwc_pkg::TAG_W-1:0]                            tag_ff, tag_in;

   logic [hwc_pkg::TIME_W-1:0]                           t;
   logic                                                 cut_now, take, close, keep;
   logic [hwc_pkg::TIME_W:0]                             limit;
   logic [hwc_pkg::NUM_CLASSES-1:0][hwc_pkg::SUM_W-1:0]  sums_new;
   logic [hwc_pkg::SUM_W-1:0]                            total_new;
   logic [hwc_pkg::SUM_W:0]                              class_wide;
   logic [TOT_W-1:0]                                     total_wide;
   logic                                                 post_open;
   logic [hwc_pkg::TIME_W-1:0]                           post_start, post_end;
   logic [hwc_pkg::TAG_W-1:0]                            post_tag;
   logic [hwc_pkg::NUM_CLASSES-1:0][hwc_pkg::SUM_W-1:0]  post_sums;
   logic [hwc_pkg::SUM_W-1:0]                            post_total;
   logic                                                 emit_a, emit_b;

   assign pop = head_valid & room;
   assign t   = head_item.hit.hit_time;

   // classify against the open cluster
   always_comb begin
      cut_now = cut_ff | head_item.over_cutoff;
      take    = ~cut_now;
      limit   = {1'b0, start_ff} + {1'b0, window_length};
      close   = take & open_ff & ({1'b0, t} > limit);
      keep    = open_ff & ~close;
   end

   // saturating class sums and total
   always_comb begin
      total_wide = keep ? TOT_W'(total_ff) : '0;
      for (int i = 0; i < hwc_pkg::NUM_CLASSES; i++) begin
         class_wide = (keep ? {1'b0, sums_ff[i]} : '0) +
                      (hwc_pkg::SUM_W + 1)'(head_item.hit.energy[i]);
         sums_new[i] = class_wide[hwc_pkg::SUM_W] ? '1 : class_wide[hwc_pkg::SUM_W-1:0];
         total_wide  = total_wide + TOT_W'(head_item.hit.energy[i]);
      end
      total_new = (total_wide[TOT_W-1:hwc_pkg::SUM_W] != '0) ? '1
                                                             : total_wide[hwc_pkg::SUM_W-1:0];
   end

   // cluster after this hit
   always_comb begin
      if (take) begin
         post_open  = 1'b1;
         post_start = keep ? start_ff : t;
         post_tag   = keep ? tag_ff : head_item.hit.tag;
         post_end   = t;
         post_sums  = sums_new;
         post_total = total_new;
      end else begin
         post_open  = open_ff;
         post_start = start_ff;
         post_tag   = tag_ff;
         post_end   = end_ff;
         post_sums  = sums_ff;
         post_total = total_ff;
      end
      emit_a = pop & close & (total_ff != '0);
      emit_b = pop & head_item.hit.last & post_open & (post_total != '0);
   end

   // next state: end of event drops the cluster and the cutoff
   always_comb begin
      open_in  = open_ff;
      cut_in   = cut_ff;
      start_in = start_ff;
      end_in   = end_ff;
      sums_in  = sums_ff;
      total_in = total_ff;
      tag_in   = tag_ff;
      if (pop) begin
         start_in = post_start;
         end_in   = post_end;
         sums_in  = post_sums;
         total_in = post_total;
         tag_in   = post_tag;
         if (head_item.hit.last) begin
            open_in = 1'b0;
            cut_in  = 1'b0;
         end else begin
            open_in = post_open;
            cut_in  = cut_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         cut_ff  <= 1'b0;
      end else begin
         open_ff <= open_in;
         cut_ff  <= cut_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      sums_ff  <= sums_in;
      total_ff <= total_in;
      tag_ff   <= tag_in;
   end

   // closed cluster first, then the flush at end of event
   always_comb begin
      push.a_valid        = emit_a;
      push.b_valid        = emit_b;
      slot_a.cluster_start = start_ff;
      slot_a.cluster_end   = end_ff;
      slot_a.sums          = sums_ff;
      slot_a.total         = total_ff;
      slot_a.tag           = tag_ff;
      slot_a.event_final   = head_item.hit.last & ~emit_b;
      slot_a.last_of_item  = ~emit_b;
      slot_b.cluster_start = post_start;
      slot_b.cluster_end   = post_end;
      slot_b.sums          = post_sums;
      slot_b.total         = post_total;
      slot_b.tag           = post_tag;
      slot_b.event_final   = 1'b1;
      slot_b.last_of_item  = 1'b1;
   end

endmodule

// File: src/hwc_result_queue.sv
// Output buffer: takes up to two clusters a cycle, hands out one per item.
// Depends on hwc_pkg.
module hwc_result_queue #(
   parameter int DEPTH = hwc_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hwc_pkg::push_type    push,
   input  hwc_pkg::rsp_type     slot_a,
   input  hwc_pkg::rsp_type     slot_b,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hwc_pkg::rsp_type     out_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hwc_pkg::rsp_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]     wr_next;
   logic [PTR_W-1:0]     b_addr;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 pop;

   // room for two results
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign wr_next   = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign b_addr    = push.a_valid ? wr_next : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.a_valid && push.b_valid) begin
         wr_ptr_in = (wr_next == PTR_W'(DEPTH - 1)) ? '0 : wr_next + 1'b1;
      end else if (push.a_valid || push.b_valid) begin
         wr_ptr_in = wr_next;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = CNT_W'(count_ff + CNT_W'(push.a_valid) + CNT_W'(push.b_valid) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store results in order
   always_ff @(posedge clock) begin
      if (push.a_valid) begin
         mem_ff[wr_ptr_ff] <= slot_a;
      end
      if (push.b_valid) begin
         mem_ff[b_addr] <= slot_b;
      end
   end

endmodule

// File: src/hit_time_window_clusterer_core.sv
// Hit time-window clusterer, top level: register port, hit queue, cluster
// engine and result queue. Depends on hwc_pkg and the three hwc_ modules.
//
// Hits of an event arrive in time order, one item per cycle at full rate. A
// hit is queued, then applied to the open cluster by the engine (window
// compare and saturating sums), which writes zero, one or two clusters to
// the result queue. Results leave at one item per cycle while rsp_ready is
// high, so a hit that both closes a cluster and ends its event yields two
// results. The engine takes a hit only when the result queue has two free
// entries. The engine registers the results of a hit in the result queue as
// it takes the hit, so the first is valid in the cycle after the take.
// window_length and late_cutoff sit at byte addresses 0 and 4 and may be
// changed only while no hit is in flight.
module hit_time_window_clusterer_core #(
   parameter int HIT_QUEUE_DEPTH = hwc_pkg::HIT_QUEUE_DEPTH,
   parameter int RSP_QUEUE_DEPTH = hwc_pkg::RSP_QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [hwc_pkg::TIME_W-1:0]           req_hit_time,
   input  logic [hwc_pkg::ENERGY_W-1:0]         req_class0_energy,
   input  logic [hwc_pkg::ENERGY_W-1:0]         req_class1_energy,
   input  logic [hwc_pkg::ENERGY_W-1:0]         req_class2_energy,
   input  logic [hwc_pkg::ENERGY_W-1:0]         req_class3_energy,
   input  logic [hwc_pkg::TAG_W-1:0]            req_detector_tag,
   input  logic                                 req_event_last_hit,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [hwc_pkg::TIME_W-1:0]           rsp_cluster_start,
   output logic [hwc_pkg::TIME_W-1:0]           rsp_cluster_end,
   output logic [hwc_pkg::SUM_W-1:0]            rsp_sum_class0,
   output logic [hwc_pkg::SUM_W-1:0]            rsp_sum_class1,
   output logic [hwc_pkg::SUM_W-1:0]            rsp_sum_class2,
   output logic [hwc_pkg::SUM_W-1:0]            rsp_sum_class3,
   output logic [hwc_pkg::SUM_W-1:0]            rsp_sum_total,
   output logic [hwc_pkg::TAG_W-1:0]            rsp_detector_out,
   output logic                                 rsp_event_final,
   output logic                                 rsp_last_of_item,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hwc_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [hwc_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [hwc_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   logic [hwc_pkg::TIME_W-1:0]   window_ff, window_in;
   logic [hwc_pkg::TIME_W-1:0]   cutoff_ff, cutoff_in;
   logic                         csr_write;
   logic                         reg_index;

   hwc_pkg::raw_hit_type         req_item;
   logic                         head_valid;
   hwc_pkg::hit_type             head_item;
   logic                         hit_pop;
   logic                         rsp_room;
   hwc_pkg::push_type            push;
   hwc_pkg::rsp_type             slot_a, slot_b;
   hwc_pkg::rsp_type             rsp_item;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      window_in = window_ff;
      cutoff_in = cutoff_ff;
      if (csr_write) begin
         unique case (reg_index)
            hwc_pkg::REG_WINDOW: window_in = csr_pwdata;
            hwc_pkg::REG_CUTOFF: cutoff_in = csr_pwdata;
            default:             window_in = window_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         hwc_pkg::REG_WINDOW: csr_prdata = window_ff;
         hwc_pkg::REG_CUTOFF: csr_prdata = cutoff_ff;
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= hwc_pkg::WINDOW_RESET;
         cutoff_ff <= hwc_pkg::CUTOFF_RESET;
      end else begin
         window_ff <= window_in;
         cutoff_ff <= cutoff_in;
      end
   end

   // pack the incoming item
   always_comb begin
      req_item.hit_time  = req_hit_time;
      req_item.energy[0] = req_class0_energy;
      req_item.energy[1] = req_class1_energy;
      req_item.energy[2] = req_class2_energy;
      req_item.energy[3] = req_class3_energy;
      req_item.tag       = req_detector_tag;
      req_item.last      = req_event_last_hit;
   end

   hwc_hit_queue #(
      .DEPTH (HIT_QUEUE_DEPTH)
   ) u_hit_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (req_valid),
      .push_ready  (req_ready),
      .push_item   (req_item),
      .late_cutoff (cutoff_ff),
      .pop         (hit_pop),
      .head_valid  (head_valid),
      .head_item   (head_item)
   );

   hwc_cluster_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .room          (rsp_room),
      .pop           (hit_pop),
      .push          (push),
      .slot_a        (slot_a),
      .slot_b        (slot_b)
   );

   hwc_result_queue #(
      .DEPTH (RSP_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .slot_a    (slot_a),
      .slot_b    (slot_b),
      .room      (rsp_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (rsp_item)
   );

   // unpack the outgoing item
   assign rsp_cluster_start = rsp_item.cluster_start;
   assign rsp_cluster_end   = rsp_item.cluster_end;
   assign rsp_sum_class0    = rsp_item.sums[0];
   assign rsp_sum_class1    = rsp_item.sums[1];
   assign rsp_sum_class2    = rsp_item.sums[2];
   assign rsp_sum_class3    = rsp_item.sums[3];
   assign rsp_sum_total     = rsp_item.total;
   assign rsp_detector_out  = rsp_item.tag;
   assign rsp_event_final   = rsp_item.event_final;
   assign rsp_last_of_item  = rsp_item.last_of_item;

   // the end of an event is always the last result of its item
   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_final |-> rsp_last_of_item)
      else $error("event_final without last_of_item");

   // results come only from a hit taken this cycle
   a_push_with_pop: assert property (@(posedge clock) disable iff (reset)
      (push.a_valid || push.b_valid) |-> hit_pop && rsp_room)
      else $error("result written without a hit");

   // two results only when the hit ends its event
   a_two_at_end: assert property (@(posedge clock) disable iff (reset)
      (push.a_valid && push.b_valid) |-> head_item.hit.last)
      else $error("two results from a hit that does not end the event");

   // nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for hit_time_window_clusterer_core: drives hits and register
// writes, predicts every cluster with a scoreboard class and checks each result item.
// Depends on hwc_pkg and the RTL of the block only.
module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 16;
   localparam int SATURATE_HITS = 1100;
   localparam int PRINT_CAP = 100;
   localparam logic [hwc_pkg::CSR_ADDR_W-1:0] ADDR_WINDOW = {hwc_pkg::REG_WINDOW, 2'b00};
   localparam logic [hwc_pkg::CSR_ADDR_W-1:0] ADDR_CUTOFF = {hwc_pkg::REG_CUTOFF, 2'b00};

   // Predict clusters from accepted hits and hold them until they come out
   class cluster_scoreboard;
      logic [hwc_pkg::TIME_W-1:0] window_len;
      logic [hwc_pkg::TIME_W-1:0] cutoff;
      bit open_flag;
      bit cut_flag;
      logic [hwc_pkg::TIME_W-1:0] open_start;
      logic [hwc_pkg::TIME_W-1:0] open_end;
      logic [hwc_pkg::NUM_CLASSES-1:0][hwc_pkg::SUM_W-1:0] sums;
      logic [hwc_pkg::SUM_W-1:0] total;
      logic [hwc_pkg::TAG_W-1:0] held_tag;
      hwc_pkg::rsp_type closed_clusters[$];
      int errors;

      function new();
         window_len = hwc_pkg::WINDOW_RESET;
         cutoff = hwc_pkg::CUTOFF_RESET;
         cut_flag = 1'b0;
         errors = 0;
         clear_cluster();
      endfunction

      function void clear_cluster();
         open_flag = 1'b0;
         open_start = '0;
         open_end = '0;
         sums = '0;
         total = '0;
         held_tag = '0;
      endfunction

      function logic [hwc_pkg::SUM_W-1:0] sat_add(logic [hwc_pkg::SUM_W-1:0] a,
                                                  logic [hwc_pkg::SUM_W-1:0] b);
         logic [hwc_pkg::SUM_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[hwc_pkg::SUM_W] ? '1 : s[hwc_pkg::SUM_W-1:0];
      endfunction

      function hwc_pkg::rsp_type snapshot();
         hwc_pkg::rsp_type r;
         r.cluster_start = open_start;
         r.cluster_end = open_end;
         r.sums = sums;
         r.total = total;
         r.tag = held_tag;
         r.event_final = 1'b0;
         r.last_of_item = 1'b0;
         return r;
      endfunction

      function int pending();
         return closed_clusters.size();
      endfunction

      // Apply one accepted hit and queue the clusters it closes
      function void note_hit(hwc_pkg::raw_hit_type h);
         hwc_pkg::rsp_type made[2];
         int n;
         n = 0;
         if (!cut_flag && h.hit_time > cutoff) cut_flag = 1'b1;
         if (!cut_flag) begin
            // window end formed in 33 bits, no wrap
            if (open_flag &&
                {1'b0, h.hit_time} > {1'b0, open_start} + {1'b0, window_len}) begin
               if (total != 0) begin
                  made[n] = snapshot();
                  n++;
               end
               clear_cluster();
            end
            if (!open_flag) begin
               open_flag = 1'b1;
               open_start = h.hit_time;
               held_tag = h.tag;
            end
            open_end = h.hit_time;
            for (int i = 0; i < hwc_pkg::NUM_CLASSES; i++) begin
               sums[i] = sat_add(sums[i],
                  {{(hwc_pkg::SUM_W-hwc_pkg::ENERGY_W){1'b0}}, h.energy[i]});
               total = sat_add(total,
                  {{(hwc_pkg::SUM_W-hwc_pkg::ENERGY_W){1'b0}}, h.energy[i]});
            end
         end
         // end of event flushes the open cluster and clears the cut
         if (h.last) begin
            if (open_flag && total != 0) begin
               made[n] = snapshot();
               n++;
            end
            clear_cluster();
            cut_flag = 1'b0;
            if (n > 0) made[n-1].event_final = 1'b1;
         end
         if (n > 0) made[n-1].last_of_item = 1'b1;
         for (int i = 0; i < n; i++) closed_clusters = {closed_clusters, made[i]};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            // keep the log short on a badly broken build
            if (errors <= PRINT_CAP)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // Compare one result item with the oldest predicted cluster
      function void check_cluster(hwc_pkg::rsp_type got);
         hwc_pkg::rsp_type want;
         if (closed_clusters.size() == 0) begin
            errors++;
            if (errors <= PRINT_CAP)
               $display("%0t: unexpected cluster, expected none, actual start %0h end %0h",
                        $time, got.cluster_start, got.cluster_end);
            return;
         end
         want = closed_clusters.pop_front();
         compare_field("cluster_start", want.cluster_start, got.cluster_start);
         compare_field("cluster_end", want.cluster_end, got.cluster_end);
         for (int i = 0; i < hwc_pkg::NUM_CLASSES; i++)
            compare_field($sformatf("sum_class%0d", i), want.sums[i], got.sums[i]);
         compare_field("sum_total", want.total, got.total);
         compare_field("detector_out", want.tag, got.tag);
         compare_field("event_final", want.event_final, got.event_final);
         compare_field("last_of_item", want.last_of_item, got.last_of_item);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [hwc_pkg::TIME_W-1:0] req_hit_time = '0;
   logic [hwc_pkg::ENERGY_W-1:0] req_class0_energy = '0;
   logic [hwc_pkg::ENERGY_W-1:0] req_class1_energy = '0;
   logic [hwc_pkg::ENERGY_W-1:0] req_class2_energy = '0;
   logic [hwc_pkg::ENERGY_W-1:0] req_class3_energy = '0;
   logic [hwc_pkg::TAG_W-1:0] req_detector_tag = '0;
   logic req_event_last_hit = 1'b0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [hwc_pkg::TIME_W-1:0] rsp_cluster_start;
   logic [hwc_pkg::TIME_W-1:0] rsp_cluster_end;
   logic [hwc_pkg::SUM_W-1:0] rsp_sum_class0;
   logic [hwc_pkg::SUM_W-1:0] rsp_sum_class1;
   logic [hwc_pkg::SUM_W-1:0] rsp_sum_class2;
   logic [hwc_pkg::SUM_W-1:0] rsp_sum_class3;
   logic [hwc_pkg::SUM_W-1:0] rsp_sum_total;
   logic [hwc_pkg::TAG_W-1:0] rsp_detector_out;
   logic rsp_event_final;
   logic rsp_last_of_item;

   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [hwc_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [hwc_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [hwc_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   cluster_scoreboard sb = new();
   int idle_pct = 0;
   int stall_left = 0;

   hit_time_window_clusterer_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_hit_time       (req_hit_time),
      .req_class0_energy  (req_class0_energy),
      .req_class1_energy  (req_class1_energy),
      .req_class2_energy  (req_class2_energy),
      .req_class3_energy  (req_class3_energy),
      .req_detector_tag   (req_detector_tag),
      .req_event_last_hit (req_event_last_hit),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cluster_start  (rsp_cluster_start),
      .rsp_cluster_end    (rsp_cluster_end),
      .rsp_sum_class0     (rsp_sum_class0),
      .rsp_sum_class1     (rsp_sum_class1),
      .rsp_sum_class2     (rsp_sum_class2),
      .rsp_sum_class3     (rsp_sum_class3),
      .rsp_sum_total      (rsp_sum_total),
      .rsp_detector_out   (rsp_detector_out),
      .rsp_event_final    (rsp_event_final),
      .rsp_last_of_item   (rsp_last_of_item),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted result item
   always @(posedge clock) begin : result_monitor
      hwc_pkg::rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.cluster_start = rsp_cluster_start;
         got.cluster_end = rsp_cluster_end;
         got.sums[0] = rsp_sum_class0;
         got.sums[1] = rsp_sum_class1;
         got.sums[2] = rsp_sum_class2;
         got.sums[3] = rsp_sum_class3;
         got.total = rsp_sum_total;
         got.tag = rsp_detector_out;
         got.event_final = rsp_event_final;
         got.last_of_item = rsp_last_of_item;
         sb.check_cluster(got);
      end
   end

   // End the run when neither channel moves an item for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("testbench NOT OK");
      $finish;
   end

   function automatic hwc_pkg::raw_hit_type make_hit(logic [hwc_pkg::TIME_W-1:0] t,
                                                     logic [hwc_pkg::ENERGY_W-1:0] e0,
                                                     logic [hwc_pkg::ENERGY_W-1:0] e1,
                                                     logic [hwc_pkg::ENERGY_W-1:0] e2,
                                                     logic [hwc_pkg::ENERGY_W-1:0] e3,
                                                     logic [hwc_pkg::TAG_W-1:0] tag,
                                                     logic last);
      hwc_pkg::raw_hit_type h;
      h.hit_time = t;
      h.energy[0] = e0;
      h.energy[1] = e1;
      h.energy[2] = e2;
      h.energy[3] = e3;
      h.tag = tag;
      h.last = last;
      return h;
   endfunction

   function automatic logic [hwc_pkg::ENERGY_W-1:0] pick_energy();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return hwc_pkg::ENERGY_W'($urandom_range(1, 15));
         default: return hwc_pkg::ENERGY_W'($urandom);
      endcase
   endfunction

   function automatic logic [hwc_pkg::TIME_W-1:0] first_time(bit top_times);
      logic [63:0] t;
      if (top_times) return 32'hFFFF_F000 + $urandom_range(0, 4095);
      case ($urandom_range(0, 7))
         0: t = 0;
         1: t = $urandom;
         2: t = (sb.cutoff > 64'd200) ? sb.cutoff - $urandom_range(0, 200) : 64'd0;
         default: t = $urandom_range(0, 2000000);
      endcase
      return t[hwc_pkg::TIME_W-1:0];
   endfunction

   // Mostly nondecreasing times aimed at the window edge, with some noise
   function automatic logic [hwc_pkg::TIME_W-1:0] next_time(logic [hwc_pkg::TIME_W-1:0] prev);
      logic [63:0] base;
      logic [63:0] t;
      base = sb.open_flag ? {32'd0, sb.open_start} : {32'd0, prev};
      case ($urandom_range(0, 19))
         0, 1, 2, 3: t = prev;
         4, 5, 6, 7, 8, 9: t = prev + $urandom_range(0, 300);
         10, 11: t = base + sb.window_len;
         12, 13: t = base + sb.window_len + 1;
         14: t = prev + ({32'd0, $urandom} % ({32'd0, sb.window_len} + 64'd1));
         15: t = sb.cutoff;
         16: t = {32'd0, sb.cutoff} + 64'd1;
         17: t = prev + $urandom_range(0, 100000);
         18: t = $urandom;
         default: t = (prev > 50) ? prev - $urandom_range(1, 50) : prev;
      endcase
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
      return t[hwc_pkg::TIME_W-1:0];
   endfunction

   // Offer one hit, with a random gap first, and hold it until accepted
   task automatic send_hit(input hwc_pkg::raw_hit_type h);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_hit_time <= h.hit_time;
      req_class0_energy <= h.energy[0];
      req_class1_energy <= h.energy[1];
      req_class2_energy <= h.energy[2];
      req_class3_energy <= h.energy[3];
      req_detector_tag <= h.tag;
      req_event_last_hit <= h.last;
      do @(posedge clock); while (!req_ready);
      sb.note_hit(h);
   endtask

   // Hold off the sender until every predicted cluster has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [hwc_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [hwc_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      // read back what was written
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== data) begin
         sb.errors++;
         $display("%0t: register %0h readback mismatch, expected %0h, actual %0h",
                  $time, addr, data, csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Change both registers once the block has gone idle
   task automatic set_config(input logic [hwc_pkg::TIME_W-1:0] window,
                             input logic [hwc_pkg::TIME_W-1:0] cutoff);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(ADDR_WINDOW, window);
      csr_write(ADDR_CUTOFF, cutoff);
      sb.window_len = window;
      sb.cutoff = cutoff;
   endtask

   // Random events until about n_items hits have been sent
   task automatic random_hits(input int n_items, input int pct, input bit top_times);
      int sent;
      int len;
      bit zero_event;
      logic [hwc_pkg::TIME_W-1:0] t;
      hwc_pkg::raw_hit_type h;
      idle_pct = pct;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         zero_event = ($urandom_range(0, 9) == 0);
         t = first_time(top_times);
         for (int k = 0; k < len; k++) begin
            if (k > 0) t = next_time(t);
            h.hit_time = t;
            for (int i = 0; i < hwc_pkg::NUM_CLASSES; i++)
               h.energy[i] = (zero_event || $urandom_range(0, 9) == 0) ? '0 : pick_energy();
            h.tag = hwc_pkg::TAG_W'($urandom);
            // now and then the final hit lacks its flag and the event runs on
            h.last = (k == len - 1) && ($urandom_range(0, 29) != 0);
            send_hit(h);
            sent++;
            if ($urandom_range(0, 199) == 0) drain_results();
         end
      end
   endtask

   initial begin : stimulus
      hwc_pkg::raw_hit_type h;
      logic [hwc_pkg::TIME_W-1:0] t0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed hits under the reset settings
      idle_pct = 10;
      // opens with full energy and the largest tag, then a hit on the window edge joins
      send_hit(make_hit(32'd100, '1, '1, '1, '1, 3'd7, 1'b0));
      send_hit(make_hit(32'd1100, '0, '0, '0, '0, 3'd0, 1'b0));
      // one past the edge closes the cluster, then an earlier time joins the new one
      send_hit(make_hit(32'd1101, 20'd1, '0, '0, '0, 3'd2, 1'b0));
      send_hit(make_hit(32'd50, '0, 20'd2, '0, '0, 3'd4, 1'b1));
      // zero-energy clusters are dropped, including at event end
      send_hit(make_hit(32'd0, '0, '0, '0, '0, 3'd1, 1'b0));
      send_hit(make_hit(32'd5000, '0, '0, '0, '0, 3'd5, 1'b0));
      send_hit(make_hit(32'd5001, '0, '0, '0, '0, 3'd6, 1'b1));
      // a hit at the cutoff counts, one past it stops collection until event end
      send_hit(make_hit(32'd10, 20'd3, '0, '0, '0, 3'd3, 1'b0));
      send_hit(make_hit(hwc_pkg::CUTOFF_RESET, '0, '0, '0, 20'd4, 3'd1, 1'b0));
      send_hit(make_hit(hwc_pkg::CUTOFF_RESET + 1, 20'd5, 20'd5, 20'd5, 20'd5, 3'd2, 1'b0));
      send_hit(make_hit(hwc_pkg::CUTOFF_RESET + 2, '1, '1, '1, '1, 3'd6, 1'b0));
      send_hit(make_hit(32'd20, 20'd7, 20'd7, 20'd7, 20'd7, 3'd0, 1'b1));
      // cut on the first hit: nothing opens, and the cut clears at event end
      send_hit(make_hit(32'hFFFF_FFFF, '1, '1, '1, '1, 3'd7, 1'b0));
      send_hit(make_hit(32'd0, 20'd1, 20'd1, 20'd1, 20'd1, 3'd0, 1'b1));
      // one hit closes a cluster and ends the event: two results
      send_hit(make_hit(32'd0, 20'h80000, '0, '0, '0, 3'd5, 1'b0));
      send_hit(make_hit(32'd2000, '0, '0, '0, 20'd1, 3'd4, 1'b1));
      // a single-hit event
      send_hit(make_hit(32'd777, '0, '0, 20'h55555, '0, 3'd1, 1'b1));
      // closing emit, then a zero-energy flush at event end
      send_hit(make_hit(32'd3000, 20'd9, 20'hAAAAA, '0, '0, 3'd3, 1'b0));
      send_hit(make_hit(32'd9000, '0, '0, '0, '0, 3'd2, 1'b1));

      // Random phases across the register settings
      set_config(32'd0, 32'hFFFF_FFFF);
      random_hits(120, 20, 1'b0);
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_hits(100, 30, 1'b1);
      set_config(32'hFFFF_FFFF, 32'd0);
      random_hits(80, 15, 1'b0);
      set_config($urandom_range(1, 5000), $urandom_range(100000, 2000000));
      random_hits(150, 10, 1'b0);
      set_config(hwc_pkg::WINDOW_RESET, hwc_pkg::CUTOFF_RESET);
      random_hits(120, 50, 1'b0);

      // One long cluster of full-energy hits drives the total sum into saturation
      set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      idle_pct = 5;
      t0 = $urandom;
      for (int k = 0; k < SATURATE_HITS; k++) begin
         h = make_hit(t0, '1, '1, '1, '1, hwc_pkg::TAG_W'($urandom), k == SATURATE_HITS - 1);
         send_hit(h);
      end

      // Last part without any idling
      set_config($urandom, $urandom);
      random_hits(130, 0, 1'b0);
      set_config($urandom_range(0, 2000), $urandom);
      random_hits(130, 0, 1'b0);

      // Wait out the remaining clusters, then give the verdict
      idle_pct = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
